@@ hdl/blp_pkg.sv @@
// Shared types and constants for the bounded positional list.
// No dependencies; imported by every module of the block.
package blp_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_TAIL  = 3'd0,
    MODE_POP_TAIL   = 3'd1,
    MODE_PUSH_FRONT = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_INSERT_AT  = 3'd4,
    MODE_ERASE_AT   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD0,
    S_DEL_TAKE,
    S_DEL_RD,
    S_DEL_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] removed_value;
    logic [LEN_W-1:0]  length_after;
    status_e           status;
  } out_item_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

endpackage

@@ hdl/bounded_positional_list_top.sv @@
// Bounded positional list: an ordered list of up to CAPACITY entries with
// push/pop at either end and insert/erase at a position. One request is
// worked at a time; after acceptance a push or insert shifts entries toward
// the back and a pop or erase moves entries toward the front, while a rejected
// or unused-mode request goes straight to its result. Each moved entry costs
// one read and one write of the single entry memory, whose read data is
// registered. The result sits in an output register, so the next request is
// accepted while the previous result waits.
// Depends on blp_pkg, blp_ctrl and blp_mem.
module bounded_positional_list_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  blp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output blp_pkg::out_item_t out_item
);
  import blp_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res_item;
  logic              out_valid_r;
  out_item_t         out_item_r;

  blp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  blp_mem u_mem (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hdl/blp_mem.sv @@
// Entry storage: one write port, one read port with registered read data.
// Depends on blp_pkg.
module blp_mem (
  input  logic                      clk,
  input  blp_pkg::mem_req_t         mem_req,
  output logic [blp_pkg::DATA_W-1:0] mem_rdata
);
  import blp_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      mem_rdata <= mem[mem_req.rd_addr];
    end
  end

endmodule

@@ hdl/blp_ctrl.sv @@
// Request decode, entry count and the shifting sequencer around one pointer adder.
// Depends on blp_pkg; drives blp_mem through a mem_req_t.
module blp_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  blp_pkg::in_item_t          in_item,
  output logic                       in_ready,
  output logic                       res_valid,
  input  logic                       res_ready,
  output blp_pkg::out_item_t         res_item,
  output blp_pkg::mem_req_t          mem_req,
  input  logic [blp_pkg::DATA_W-1:0] mem_rdata
);
  import blp_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] removed_r, removed_nxt;
  status_e           stat_r, stat_nxt;
  logic              is_ins_r, is_ins_nxt;

  logic              full, empty;
  logic [CNT_W-1:0]  pos_c, clamp_c, last_c;
  logic              dec_reject, dec_ins;
  logic [IDX_W-1:0]  dec_pos;
  status_e           dec_stat;
  logic [CNT_W-1:0]  step_sum;
  logic              del_end;

  // request decode, against the current count
  always_comb begin
    full       = (count_r == CAP_CNT);
    empty      = (count_r == '0);
    pos_c      = CNT_W'(in_item.position);
    clamp_c    = (pos_c > count_r) ? count_r : pos_c;
    last_c     = count_r - CNT_W'(1);
    dec_reject = 1'b1;
    dec_ins    = 1'b0;
    dec_pos    = '0;
    dec_stat   = STAT_OK;
    unique case (in_item.mode)
      MODE_PUSH_TAIL, MODE_PUSH_FRONT, MODE_INSERT_AT: begin
        dec_ins = 1'b1;
        if (full) begin
          dec_stat = STAT_FULL;
        end else begin
          dec_reject = 1'b0;
          if (in_item.mode == MODE_PUSH_TAIL) begin
            dec_pos = count_r[IDX_W-1:0];
          end else if (in_item.mode == MODE_PUSH_FRONT) begin
            dec_pos = '0;
          end else begin
            dec_pos = clamp_c[IDX_W-1:0];
          end
        end
      end
      MODE_POP_TAIL, MODE_POP_FRONT: begin
        if (empty) begin
          dec_stat = STAT_EMPTY;
        end else begin
          dec_reject = 1'b0;
          dec_pos    = (in_item.mode == MODE_POP_TAIL) ? last_c[IDX_W-1:0] : '0;
        end
      end
      MODE_ERASE_AT: begin
        if (empty) begin
          dec_stat = STAT_EMPTY;
        end else if (pos_c >= count_r) begin
          dec_stat = STAT_RANGE;
        end else begin
          dec_reject = 1'b0;
          dec_pos    = pos_c[IDX_W-1:0];
        end
      end
      default: begin
        dec_stat = STAT_OK;
      end
    endcase
  end

  // shared pointer adder: down for insert, up for erase
  assign step_sum = CNT_W'(ptr_r) + (is_ins_r ? {CNT_W{1'b1}} : CNT_W'(1));
  assign del_end  = (step_sum >= count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (dec_reject) state_nxt = S_DONE;
          else if (dec_ins) state_nxt = S_INS_RD;
          else state_nxt = S_DEL_RD0;
        end
      end
      S_INS_RD:   state_nxt = (ptr_r == pos_r) ? S_INS_PUT : S_INS_WR;
      S_INS_WR:   state_nxt = S_INS_RD;
      S_INS_PUT:  state_nxt = S_DONE;
      S_DEL_RD0:  state_nxt = S_DEL_TAKE;
      S_DEL_TAKE: state_nxt = S_DEL_RD;
      S_DEL_RD:   state_nxt = del_end ? S_DONE : S_DEL_WR;
      S_DEL_WR:   state_nxt = S_DEL_RD;
      S_DONE:     state_nxt = res_ready ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    removed_nxt = removed_r;
    stat_nxt    = stat_r;
    is_ins_nxt  = is_ins_r;
    mem_req     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ptr_nxt     = dec_ins ? count_r[IDX_W-1:0] : dec_pos;
          pos_nxt     = dec_pos;
          val_nxt     = in_item.item_value;
          removed_nxt = '0;
          stat_nxt    = dec_stat;
          is_ins_nxt  = dec_ins;
        end
      end
      S_INS_RD: begin
        if (ptr_r != pos_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = step_sum[IDX_W-1:0];
        end
      end
      S_INS_WR, S_DEL_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ptr_r;
        mem_req.wr_data = mem_rdata;
        ptr_nxt         = step_sum[IDX_W-1:0];
      end
      S_INS_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r;
        mem_req.wr_data = val_r;
        count_nxt       = count_r + CNT_W'(1);
      end
      S_DEL_RD0: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = pos_r;
      end
      S_DEL_TAKE: begin
        removed_nxt = mem_rdata;
      end
      S_DEL_RD: begin
        if (del_end) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = step_sum[IDX_W-1:0];
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_item  = '{removed_value: removed_r,
                       length_after:  LEN_W'(count_r),
                       status:        stat_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    removed_r <= removed_nxt;
    stat_r    <= stat_nxt;
    is_ins_r  <= is_ins_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("memory write outside a shift sequence");

  a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_PUT) |-> (count_r < CAP_CNT))
    else $error("insert into full list");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_ready) |=> (state_r == S_DONE))
    else $error("result dropped while stalled");

  a_count_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_IDLE && state_r != S_INS_PUT && state_r != S_DEL_RD)
      |=> $stable(count_r))
    else $error("count changed outside commit state");

endmodule
